// File: hw/rtl/loudness_column_envelope_assert.svh
// Assertion macros for the loudness column envelope block.
// Used by loudness_column_envelope.sv; expects signals clock and reset in scope.
`ifndef LOUDNESS_COLUMN_ENVELOPE_ASSERT_SVH
`define LOUDNESS_COLUMN_ENVELOPE_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define LCE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define LCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lce_pkg.sv
// Package for the loudness column envelope: field widths, types, constants,
// register indexes and the height saturation function. No dependencies.
`timescale 1ns / 1ps

package lce_pkg;

   // Field and register widths
   localparam int SAMPLE_W    = 16;
   localparam int COL_W       = 6;
   localparam int Y_W         = 8;
   localparam int FRAME_W     = 13;
   localparam int COUNT_W     = 7;
   localparam int HEIGHT_W    = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // Frame position and split widths
   localparam int POS_W  = 12;
   localparam int HALF_W = 12;
   localparam int J_W    = 11;
   localparam int PJ_W   = J_W + COL_W;

   // Shared multiplier widths
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 14;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_FRAME   = 4096;

   // Height scale: y = (H-1)*(s+DB_OFFSET)/36864, 36864 = 4096 * 9.
   // The divide by 9 is a multiply by RECIP_NINE and a shift.
   localparam int DB_OFFSET    = 15360;
   localparam int SCALE_SHIFT  = 12;
   localparam int ABS_W        = 11;
   localparam int RECIP_NINE   = 7282;
   localparam int RECIP_SHIFT  = 16;

   typedef logic signed [SAMPLE_W-1:0]   sample_type;
   typedef logic        [COL_W-1:0]      column_type;
   typedef logic signed [Y_W-1:0]        height_type;
   typedef logic        [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic        [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_FRAME_SAMPLES  = 2'd0;
   localparam csr_index_type CSR_COLUMN_COUNT   = 2'd1;
   localparam csr_index_type CSR_DISPLAY_HEIGHT = 2'd2;

   localparam logic [FRAME_W-1:0]  FRAME_SAMPLES_RESET  = 13'd16;
   localparam logic [COUNT_W-1:0]  COLUMN_COUNT_RESET   = 7'd64;
   localparam logic [HEIGHT_W-1:0] DISPLAY_HEIGHT_RESET = 7'd64;

   localparam height_type Y_MAX = 8'sd127;
   localparam height_type Y_MIN = -8'sd128;

   // Apply sign to a magnitude and clamp to the signed 8-bit range.
   function automatic height_type sat_height(input logic neg, input logic [Y_W-1:0] mag);
      height_type r;
      if (!neg) begin
         r = (mag > 8'd127) ? Y_MAX : height_type'(mag);
      end else begin
         r = (mag > 8'd128) ? Y_MIN : height_type'(-mag);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/loudness_column_envelope.sv
// Loudness column envelope: per-column min/max of a frame's middle half.
// A sample outside the middle half skips the arithmetic; a kept one runs the full sequence.
// Throughput: one item at a time; a kept sample holds the multiplier and divider.
// End of frame: columns are reported in column order, each held until taken.
// Reset (synchronous, active high): registers to 16/64/64, frame position to 0;
// column store contents are undefined until the first sample of a frame.
`timescale 1ns / 1ps

module loudness_column_envelope (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lce_pkg::sample_type    req_sample_db,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lce_pkg::column_type    rsp_column,
   output lce_pkg::height_type    rsp_low_y,
   output lce_pkg::height_type    rsp_high_y,
   output logic                   rsp_last_column,
   // register writes
   input  logic                   csr_write_en,
   input  lce_pkg::csr_index_type csr_index,
   input  lce_pkg::csr_data_type  csr_wdata
);

   import lce_pkg::*;

`include "loudness_column_envelope_assert.svh"

   // Sequencer: its states issue steps on the shared multiplier or the
   // compare-subtract divider, clamp, touch the column store, or report.
   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_MULY  = 13'b0000000000010,  // (H-1)*(s+offset)
      S_SCALE = 13'b0000000000100,  // |p|>>12 times reciprocal of 9
      S_SAT   = 13'b0000000001000,  // sign and clamp height
      S_MULC  = 13'b0000000010000,  // offset*columns
      S_DLOAD = 13'b0000000100000,  // seed divider remainder
      S_DIV   = 13'b0000001000000,  // one quotient bit a cycle
      S_RD    = 13'b0000010000000,  // read column entry
      S_UPD   = 13'b0000100000000,  // merge height, write back
      S_FIN   = 13'b0001000000000,  // advance frame position
      S_RRD   = 13'b0010000000000,  // report: read column entry
      S_RCALC = 13'b0100000000000,  // report: gap fill, load output
      S_ROUT  = 13'b1000000000000   // report: hold until taken
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [FRAME_W-1:0]  frame_samples_ff;
   logic [COUNT_W-1:0]  column_count_ff;
   logic [HEIGHT_W-1:0] display_height_ff;

   // Frame and item state
   logic [POS_W-1:0]    pos_ff, pos_in;
   sample_type          sample_ff, sample_in;
   logic [J_W-1:0]      j_ff, j_in;
   logic [HEIGHT_W-1:0] clr_h_ff, clr_h_in;
   logic [MAX_COLUMNS-1:0] valid_ff, valid_in;

   // Shared arithmetic
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   height_type               y_ff, y_in;
   logic [HALF_W-1:0]        rem_ff, rem_in;
   logic [COL_W-1:0]         low_ff, low_in;
   column_type               x_ff, x_in;
   logic [2:0]               step_ff, step_in;

   // Report sweep
   column_type  idx_ff, idx_in;
   height_type  prev_min_ff, prev_min_in;
   height_type  prev_max_ff, prev_max_in;
   logic        rsp_valid_ff, rsp_valid_in;
   column_type  rsp_column_ff, rsp_column_in;
   height_type  rsp_low_ff, rsp_low_in;
   height_type  rsp_high_ff, rsp_high_in;
   logic        rsp_last_ff, rsp_last_in;

   // Column store: {min, max} per column, one read and one write port
   logic [2*Y_W-1:0] col_mem [MAX_COLUMNS];
   logic [2*Y_W-1:0] rd_data_ff;
   column_type       rd_addr;
   logic             mem_we;
   height_type       upd_min, upd_max;

   // Derived configuration
   logic [FRAME_W-1:0] n_eff;
   logic [COUNT_W-1:0] cols_eff;
   logic [HALF_W-1:0]  half, start;
   logic               keep;
   logic [FRAME_W-1:0] pos_next;

   // Multiplier operands and product
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]  abs_p;

   // Divider step
   logic [HALF_W:0] trial;
   logic            ge;

   // Column entry as seen after clear
   height_type clr_min, clr_max;
   height_type cur_min, cur_max;
   logic       cur_valid;
   logic       req_fire;

   // Clamp frame length to 1..4096 and columns to the store depth
   always_comb begin
      if (frame_samples_ff == '0) begin
         n_eff = FRAME_W'(1);
      end else if (frame_samples_ff > FRAME_W'(MAX_FRAME)) begin
         n_eff = FRAME_W'(MAX_FRAME);
      end else begin
         n_eff = frame_samples_ff;
      end
   end

   assign cols_eff = (column_count_ff > COUNT_W'(MAX_COLUMNS)) ? COUNT_W'(MAX_COLUMNS)
                                                               : column_count_ff;
   assign half     = n_eff[FRAME_W-1:1];
   assign start    = half - (half >> 1);
   assign keep     = (pos_ff >= start)
                     && ({1'b0, pos_ff} < ({1'b0, start} + {1'b0, half}))
                     && (cols_eff != '0);
   assign pos_next = {1'b0, pos_ff} + FRAME_W'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Shared multiplier: operands picked by the sequencer
   assign abs_p = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;

   always_comb begin
      case (state_ff)
         S_MULY: begin
            mul_a = MUL_A_W'(sample_ff) + MUL_A_W'(DB_OFFSET);
            mul_b = $signed(MUL_B_W'(display_height_ff)) - $signed(MUL_B_W'(1));
         end
         S_SCALE: begin
            mul_a = $signed(MUL_A_W'(abs_p[SCALE_SHIFT+ABS_W-1:SCALE_SHIFT]));
            mul_b = $signed(MUL_B_W'(RECIP_NINE));
         end
         S_MULC: begin
            mul_a = $signed(MUL_A_W'(j_ff));
            mul_b = $signed(MUL_B_W'(cols_eff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Restoring divide step against half
   assign trial = {rem_ff, low_ff[COL_W-1]};
   assign ge    = (trial >= {1'b0, half});

   // Column store read side; entries not touched this frame read as cleared
   assign rd_addr   = (state_ff == S_RRD) ? idx_ff : x_ff;
   assign clr_min   = $signed({1'b0, clr_h_ff});
   assign clr_max   = -clr_min;
   assign cur_valid = (state_ff == S_RCALC) ? valid_ff[idx_ff] : valid_ff[x_ff];
   assign cur_min   = cur_valid ? rd_data_ff[2*Y_W-1:Y_W] : clr_min;
   assign cur_max   = cur_valid ? rd_data_ff[Y_W-1:0]     : clr_max;
   assign upd_min   = (y_ff < cur_min) ? y_ff : cur_min;
   assign upd_max   = (y_ff > cur_max) ? y_ff : cur_max;
   assign mem_we    = (state_ff == S_UPD);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      j_in         = j_ff;
      clr_h_in     = clr_h_ff;
      valid_in     = valid_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      y_in         = y_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      x_in         = x_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      prev_min_in  = prev_min_ff;
      prev_max_in  = prev_max_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_column_in = rsp_column_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sample_in = req_sample_db;
               j_in      = J_W'(pos_ff - start);
               // first sample of a frame: drop all column entries
               if (pos_ff == '0) begin
                  valid_in = '0;
                  clr_h_in = display_height_ff;
               end
               state_in = keep ? S_MULY : S_FIN;
            end
         end
         S_MULY: begin
            prod_in  = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_in  = mul_p;
            neg_in   = prod_ff[PROD_W-1];
            state_in = S_SAT;
         end
         S_SAT: begin
            y_in     = sat_height(neg_ff, prod_ff[RECIP_SHIFT+Y_W-1:RECIP_SHIFT]);
            state_in = S_MULC;
         end
         S_MULC: begin
            prod_in  = mul_p;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            // product < half*64, so its top bits are already below half
            rem_in   = HALF_W'(prod_ff[PJ_W-1:COL_W]);
            low_in   = prod_ff[COL_W-1:0];
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = ge ? HALF_W'(trial - {1'b0, half}) : HALF_W'(trial);
            low_in  = {low_ff[COL_W-2:0], 1'b0};
            x_in    = {x_ff[COL_W-2:0], ge};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(COL_W - 1)) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            valid_in[x_ff] = 1'b1;
            state_in       = S_FIN;
         end
         S_FIN: begin
            if (pos_next < n_eff) begin
               pos_in   = POS_W'(pos_next);
               state_in = S_IDLE;
            end else begin
               pos_in = '0;
               idx_in = '0;
               state_in = (cols_eff == '0) ? S_IDLE : S_RRD;
            end
         end
         S_RRD: begin
            state_in = S_RCALC;
         end
         S_RCALC: begin
            // gap fill against the already filled left neighbor
            if (idx_ff == '0) begin
               rsp_low_in  = cur_min;
               rsp_high_in = cur_max;
            end else begin
               rsp_low_in  = (prev_max_ff < cur_min) ? prev_max_ff : cur_min;
               rsp_high_in = (prev_min_ff > cur_max) ? prev_min_ff : cur_max;
            end
            prev_min_in   = rsp_low_in;
            prev_max_in   = rsp_high_in;
            rsp_column_in = idx_ff;
            rsp_last_in   = (COUNT_W'(idx_ff) == (cols_eff - COUNT_W'(1)));
            rsp_valid_in  = 1'b1;
            state_in      = S_ROUT;
         end
         S_ROUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + COL_W'(1);
                  state_in = S_RRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         pos_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
         frame_samples_ff  <= FRAME_SAMPLES_RESET;
         column_count_ff   <= COLUMN_COUNT_RESET;
         display_height_ff <= DISPLAY_HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_SAMPLES:  frame_samples_ff  <= csr_wdata[FRAME_W-1:0];
               CSR_COLUMN_COUNT:   column_count_ff   <= csr_wdata[COUNT_W-1:0];
               CSR_DISPLAY_HEIGHT: display_height_ff <= csr_wdata[HEIGHT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      j_ff          <= j_in;
      clr_h_ff      <= clr_h_in;
      valid_ff      <= valid_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      y_ff          <= y_in;
      rem_ff        <= rem_in;
      low_ff        <= low_in;
      x_ff          <= x_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      prev_min_ff   <= prev_min_in;
      prev_max_ff   <= prev_max_in;
      rsp_column_ff <= rsp_column_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Column store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem[x_ff] <= {upd_min, upd_max};
      end
      rd_data_ff <= col_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_low_y       = rsp_low_ff;
   assign rsp_high_y      = rsp_high_ff;
   assign rsp_last_column = rsp_last_ff;

   // Checks
   `LCE_ASSERT_IMPL(a_no_accept_in_report, rsp_valid_ff, !req_ready, "item accepted while reporting")
   `LCE_ASSERT_IMPL(a_column_in_range, rsp_valid_ff, COUNT_W'(idx_ff) < cols_eff, "column out of range")
   `LCE_ASSERT_IMPL(a_div_step_bound, state_ff == S_DIV, step_ff < 3'(COL_W), "divider overran")
   `LCE_ASSERT_NEXT(a_frame_start_clears, req_fire && (pos_ff == '0), valid_ff == '0, "frame start kept stale columns")

endmodule
